### sv/plv_pkg.sv
// ----------------------------------------------------------------------------
// plv_pkg
// Shared types and constants for the positional value list.
// ----------------------------------------------------------------------------
package plv_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 1024;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  localparam int unsigned IN_FIELDS_W  = VALUE_W + POS_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = VALUE_W + COUNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int unsigned TUSER_W      = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_CLAMPED = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

endpackage

### sv/plv_mem.sv
// ----------------------------------------------------------------------------
// plv_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module plv_mem #(
  parameter int unsigned DEPTH = plv_pkg::DEFAULT_CAPACITY,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [plv_pkg::VALUE_W-1:0]  wr_data_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [plv_pkg::VALUE_W-1:0]  rd_data_o
);
  import plv_pkg::*;

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/plv_ctrl.sv
// ----------------------------------------------------------------------------
// plv_ctrl
// Request sequencer: clamps the position; for insert and remove, walks the entry
// memory one entry per read/write pair to open or close a gap; registers the result.
// ----------------------------------------------------------------------------
module plv_ctrl #(
  parameter int unsigned CAPACITY = plv_pkg::DEFAULT_CAPACITY,
  localparam int unsigned IW      = $clog2(CAPACITY),
  localparam int unsigned LW      = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [plv_pkg::MODE_W-1:0]    in_mode_i,
  input  logic [plv_pkg::VALUE_W-1:0]   in_value_i,
  input  logic [plv_pkg::POS_W-1:0]     in_pos_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [plv_pkg::VALUE_W-1:0]   out_value_o,
  output logic [plv_pkg::STATUS_W-1:0]  out_status_o,
  output logic [plv_pkg::COUNT_W-1:0]   out_count_o,
  output logic                          mem_rd_en_o,
  output logic [IW-1:0]                 mem_rd_addr_o,
  output logic                          mem_wr_en_o,
  output logic [IW-1:0]                 mem_wr_addr_o,
  output logic [plv_pkg::VALUE_W-1:0]   mem_wr_data_o,
  input  logic [plv_pkg::VALUE_W-1:0]   mem_rd_data_i
);
  import plv_pkg::*;

  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_RD   = 5'b00100,
    S_WR   = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [LW-1:0]      len_q, len_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      p_q, p_d;
  status_e            status_q, status_d;
  logic               is_read_q, is_read_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  status_e            out_status_q, out_status_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic [CW-1:0] pos_ext, len_ext;
  logic [IW-1:0] pc;
  logic          pc_clamped;

  assign pos_ext    = CW'(pos_q);
  assign len_ext    = CW'(len_q);
  assign pc_clamped = (pos_ext >= len_ext);
  assign pc         = pc_clamped ? IW'(len_q - LW'(1)) : IW'(pos_q);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    value_d      = value_q;
    pos_d        = pos_q;
    len_d        = len_q;
    idx_d        = idx_q;
    p_d          = p_q;
    status_d     = status_q;
    is_read_d    = is_read_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = idx_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = idx_q;
    mem_wr_data_o = mem_rd_data_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_e'(in_mode_i);
          value_d = in_value_i;
          pos_d   = in_pos_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        is_read_d = 1'b0;
        status_d  = ST_OK;
        case (mode_q)
          MODE_INSERT: begin
            if (len_q == LW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              if (pos_ext > len_ext) begin
                p_d      = IW'(len_q);
                status_d = ST_CLAMPED;
              end else begin
                p_d = IW'(pos_q);
              end
              idx_d   = IW'(len_q);
              state_d = S_RD;
            end
          end
          MODE_REMOVE: begin
            if (len_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              status_d = pc_clamped ? ST_CLAMPED : ST_OK;
              idx_d    = pc;
              state_d  = S_RD;
            end
          end
          MODE_READ: begin
            if (len_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              status_d      = pc_clamped ? ST_CLAMPED : ST_OK;
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = pc;
              is_read_d     = 1'b1;
            end
            state_d = S_RESP;
          end
          MODE_CLEAR: begin
            len_d   = '0;
            state_d = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_RD: begin
        if (mode_q == MODE_INSERT) begin
          if (idx_q > p_q) begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = idx_q - IW'(1);
            state_d       = S_WR;
          end else begin
            mem_wr_en_o   = 1'b1;
            mem_wr_addr_o = p_q;
            mem_wr_data_o = value_q;
            len_d         = len_q + LW'(1);
            state_d       = S_RESP;
          end
        end else begin
          if ((LW'(idx_q) + LW'(1)) < len_q) begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = idx_q + IW'(1);
            state_d       = S_WR;
          end else begin
            len_d   = len_q - LW'(1);
            state_d = S_RESP;
          end
        end
      end
      S_WR: begin
        mem_wr_en_o = 1'b1;
        idx_d       = (mode_q == MODE_INSERT) ? idx_q - IW'(1) : idx_q + IW'(1);
        state_d     = S_RD;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_value_d  = is_read_q ? mem_rd_data_i : '0;
          out_status_d = status_q;
          out_count_d  = COUNT_W'(len_q);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    value_q      <= value_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    p_q          <= p_d;
    status_q     <= status_d;
    is_read_q    <= is_read_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

endmodule

### sv/positional_value_list.sv
// ----------------------------------------------------------------------------
// positional_value_list
// Ordered list of signed 64-bit values with positional insert, remove, read
// and clear.
//
//   channel  dir  tdata (low bit up)              tuser
//   s_axis   in   item_value[63:0] position[73:64] mode[1:0]
//   m_axis   out  read_value[63:0] count[74:64]    status[1:0]
//
// Insert and remove shift every entry between the position and the list end;
// read, clear and refused requests shift none.
// Each shifted entry costs one memory read and one memory write.
// Reset clears the length only; entry memory is not cleared.
// The result register frees the input side; a stalled result holds the
// block only when the next result is ready to load.
// ----------------------------------------------------------------------------
module positional_value_list #(
  parameter int unsigned CAPACITY = plv_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [plv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // item_value, position
  input  logic [plv_pkg::TUSER_W-1:0]      s_axis_tuser,  // mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [plv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // read_value, count
  output logic [plv_pkg::TUSER_W-1:0]      m_axis_tuser   // status
);
  import plv_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);

  logic               rd_en, wr_en;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;
  logic [VALUE_W-1:0] out_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_count;

  plv_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_mode_i     (s_axis_tuser[MODE_W-1:0]),
    .in_value_i    (s_axis_tdata[VALUE_W-1:0]),
    .in_pos_i      (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_value_o   (out_value),
    .out_status_o  (out_status),
    .out_count_o   (out_count),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data),
    .mem_rd_data_i (rd_data)
  );

  plv_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_value};
  assign m_axis_tuser = {{(TUSER_W - STATUS_W){1'b0}}, out_status};

endmodule

### sv/plv_checker.sv
// ----------------------------------------------------------------------------
// plv_checker
// Port-level checks for the positional value list, bound to the top level.
// ----------------------------------------------------------------------------
module plv_checker #(
  parameter int unsigned CAPACITY = plv_pkg::DEFAULT_CAPACITY
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [plv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [plv_pkg::TUSER_W-1:0]      m_axis_tuser
);
  import plv_pkg::*;

  logic [COUNT_W-1:0]  cnt;
  logic [STATUS_W-1:0] st;
  logic [VALUE_W-1:0]  rv;

  assign rv  = m_axis_tdata[VALUE_W-1:0];
  assign cnt = m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W];
  assign st  = m_axis_tuser[STATUS_W-1:0];

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a request is in progress");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st == ST_FULL) |-> (cnt == COUNT_W'(CAPACITY) && rv == '0))
    else $error("full status with wrong count or value");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st == ST_EMPTY) |-> (cnt == '0 && rv == '0))
    else $error("empty status with nonzero count or value");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CAPACITY > 2047 || 32'(cnt) <= CAPACITY))
    else $error("count above capacity");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind positional_value_list plv_checker #(.CAPACITY(CAPACITY)) u_plv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for positional_value_list. A short table of directed
// requests covers the empty list, clamped positions, the value extremes and
// clear. Random request bursts follow, along with one fill to capacity that
// exercises refused inserts and full-length shifts. Every result is compared
// field by field with an in-order prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plv_pkg::*;

  localparam int unsigned LIST_CAP    = DEFAULT_CAPACITY;
  localparam int unsigned RAND_ITEMS  = 800;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT  = 10000;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned NUM_DIR     = 20;
  localparam logic [VALUE_W-1:0] V_MIN = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] V_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [POS_W-1:0]   P_END = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    mode_e              mode;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    bit                 has_exp;
    list_result_t       exp;
  } dir_row_t;

  localparam list_result_t NO_EXP = '{64'h0, ST_OK, 11'd0};

  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{MODE_READ,   64'h0,                  10'd0,   1'b1, '{64'h0, ST_EMPTY,   11'd0}},
    '{MODE_REMOVE, 64'h0,                  P_END,   1'b1, '{64'h0, ST_EMPTY,   11'd0}},
    '{MODE_INSERT, V_MIN,                  10'd0,   1'b1, '{64'h0, ST_OK,      11'd1}},
    '{MODE_INSERT, V_MAX,                  P_END,   1'b1, '{64'h0, ST_CLAMPED, 11'd2}},
    '{MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1,  1'b0, NO_EXP},
    '{MODE_READ,   64'h0,                  10'd0,   1'b0, NO_EXP},
    '{MODE_READ,   64'h0,                  P_END,   1'b0, NO_EXP},
    '{MODE_READ,   64'h0,                  10'd3,   1'b0, NO_EXP},
    '{MODE_INSERT, 64'h0,                  10'd3,   1'b0, NO_EXP},
    '{MODE_INSERT, 64'h5555_5555_5555_5555, 10'd2,  1'b0, NO_EXP},
    '{MODE_READ,   64'h0,                  10'd2,   1'b0, NO_EXP},
    '{MODE_REMOVE, 64'h0,                  10'd0,   1'b0, NO_EXP},
    '{MODE_REMOVE, 64'h0,                  P_END,   1'b0, NO_EXP},
    '{MODE_REMOVE, 64'h0,                  10'd1,   1'b0, NO_EXP},
    '{MODE_READ,   64'h0,                  10'd1,   1'b0, NO_EXP},
    '{MODE_CLEAR,  64'h0,                  10'd0,   1'b1, '{64'h0, ST_OK,      11'd0}},
    '{MODE_READ,   64'h0,                  10'd0,   1'b1, '{64'h0, ST_EMPTY,   11'd0}},
    '{MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 10'd5,  1'b1, '{64'h0, ST_CLAMPED, 11'd1}},
    '{MODE_CLEAR,  V_MAX,                  P_END,   1'b1, '{64'h0, ST_OK,      11'd0}},
    '{MODE_REMOVE, 64'h0,                  10'd0,   1'b1, '{64'h0, ST_EMPTY,   11'd0}}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [TUSER_W-1:0]     s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [TUSER_W-1:0]     m_axis_tuser;

  logic [VALUE_W-1:0] list_model [$];
  list_result_t       results_due [$];
  int unsigned        fail_count = 0;
  int unsigned        result_idx = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        burst_left = 1;
  bit                 hold_req = 1'b0;

  positional_value_list #(
    .CAPACITY(LIST_CAP)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Applies one request to the list copy and returns the result it produces.
  function automatic list_result_t list_apply(mode_e mode, logic [VALUE_W-1:0] value,
                                              logic [POS_W-1:0] pos_in);
    list_result_t r;
    int unsigned  pos;
    int unsigned  len;
    r            = '0;
    r.status     = ST_OK;
    pos          = pos_in;
    len          = list_model.size();
    case (mode)
      MODE_INSERT: begin
        if (len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          if (pos > len) begin
            pos      = len;
            r.status = ST_CLAMPED;
          end
          list_model.insert(pos, value);
        end
      end
      MODE_REMOVE, MODE_READ: begin
        if (len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (pos >= len) begin
            pos      = len - 1;
            r.status = ST_CLAMPED;
          end
          if (mode == MODE_READ) r.read_value = list_model[pos];
          else list_model.delete(pos);
        end
      end
      default: begin
        list_model.delete();
      end
    endcase
    r.count = COUNT_W'(list_model.size());
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return V_MIN;
      1: return V_MAX;
      2: return '0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one request and returns at the edge where it transfers.
  task automatic send_req(mode_e mode, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos,
                          bit has_exp, list_result_t exp);
    list_result_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({pos, value});
    s_axis_tuser  <= TUSER_W'(mode);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = list_apply(mode, value, pos);
    results_due.push_back(has_exp ? exp : pred);
  endtask

  // Request inside a burst; a random gap, sometimes none, follows the end of each burst.
  task automatic issue(mode_e mode, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
    int unsigned gap;
    send_req(mode, value, pos, 1'b0, NO_EXP);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return P_END;
      2, 3: return POS_W'($urandom_range(0, 1023));
      default: return POS_W'($urandom_range(0, list_model.size()));
    endcase
  endfunction

  task automatic random_op();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 3) issue(MODE_CLEAR, rand_value(), rand_pos());
    else if (k < ((list_model.size() > 48) ? 20 : 45)) issue(MODE_INSERT, rand_value(), rand_pos());
    else if (k < 70) issue(MODE_REMOVE, rand_value(), rand_pos());
    else issue(MODE_READ, rand_value(), rand_pos());
  endtask

  // Grow the list to capacity, mostly by appends, then probe the full list.
  task automatic fill_list();
    int unsigned len;
    issue(MODE_CLEAR, '0, '0);
    while (list_model.size() < LIST_CAP) begin
      len = list_model.size();
      if ($urandom_range(0, 15) == 0 && len > 0)
        issue(MODE_INSERT, rand_value(), POS_W'(len - $urandom_range(0, (len < 4) ? len : 4)));
      else
        issue(MODE_INSERT, rand_value(), POS_W'($urandom_range(len, 1023)));
    end
    issue(MODE_INSERT, rand_value(), '0);
    issue(MODE_INSERT, rand_value(), P_END);
    issue(MODE_READ, '0, P_END);
    issue(MODE_READ, '0, '0);
    issue(MODE_REMOVE, '0, '0);
    issue(MODE_INSERT, rand_value(), '0);
    issue(MODE_READ, '0, '0);
    repeat (20) issue(MODE_REMOVE, '0, P_END);
    issue(MODE_CLEAR, '0, '0);
  endtask

  initial begin : stimulus
    int unsigned rand_done;
    int unsigned seq;
    int unsigned kind;
    int unsigned n;
    bit          filled;
    rand_done = 0;
    seq       = 0;
    filled    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_req(DIR_TAB[i].mode, DIR_TAB[i].value, DIR_TAB[i].pos,
               DIR_TAB[i].has_exp, DIR_TAB[i].exp);
    end
    drain();

    while (rand_done < RAND_ITEMS) begin
      seq++;
      kind = (seq == 2) ? 0 : (seq == 4) ? 1 : $urandom_range(0, 11);
      if (kind == 0) begin
        // receiver holds off while requests keep coming back to back
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) begin
          send_req(MODE_INSERT, rand_value(), rand_pos(), 1'b0, NO_EXP);
        end
        rand_done += 24;
      end else if (kind == 1) begin
        drain();
      end else begin
        n = $urandom_range(8, 40);
        repeat (n) random_op();
        rand_done += n;
      end
      if (!filled && rand_done >= RAND_ITEMS / 2) begin
        fill_list();
        filled = 1'b1;
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_ready
    logic [15:0] stall_mask;
    int unsigned left;
    int unsigned bit_idx;
    stall_mask = '1;
    left       = 0;
    bit_idx    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_mask = '1;
            1: stall_mask = 16'($urandom);
            2: stall_mask = 16'($urandom | $urandom);
            default: stall_mask = 16'($urandom & $urandom);
          endcase
          left = $urandom_range(16, 128);
        end
        left--;
        m_axis_tready <= stall_mask[bit_idx[3:0]];
        bit_idx++;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_value = m_axis_tdata[VALUE_W-1:0];
        got.count      = m_axis_tdata[VALUE_W +: COUNT_W];
        got.status     = status_e'(m_axis_tuser[STATUS_W-1:0]);
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: unexpected, value %h status %0d count %0d",
                     result_idx, got.read_value, got.status, got.count);
        end else begin
          want = results_due.pop_front();
          if (got.read_value !== want.read_value || got.status !== want.status ||
              got.count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected value %h status %0d count %0d, got value %h status %0d count %0d",
                       result_idx, want.read_value, want.status, want.count,
                       got.read_value, got.status, got.count);
          end
        end
        result_idx++;
      end
    end
  end

endmodule
